### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// condition that implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");

// condition that implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed");

`endif

### rtl/core/ple_pkg.sv
// types, codes and helpers of the positional list engine
package ple_pkg;

   localparam int CAPACITY_DEFAULT  = 256;
   localparam int WORD_BITS_DEFAULT = 32;
   localparam int POS_BITS          = 9;
   localparam int LEN_BITS          = 9;
   localparam int VALUE_BITS        = 32;
   localparam int TREE_FAN          = 16;

   // request operation codes
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_WRITE  = 2'd3
   } cmd_type;

   // result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BADPOS = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   // what each cell of the chain does on an accepted item
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2,
      CELL_WRITE  = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic        load;
      logic        fetch;
      cell_op_type op;
   } cell_ctl_type;

   typedef struct packed {
      cmd_type                      cmd;
      logic [POS_BITS-1:0]          position;
      logic signed [VALUE_BITS-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic signed [VALUE_BITS-1:0] value_out;
      logic [LEN_BITS-1:0]          length;
   } rsp_type;

   // number of registered levels of the select tree for a given leaf count
   function automatic int tree_levels(input int leaves);
      int lv;
      int span;
      lv   = 1;
      span = TREE_FAN;
      while (span < leaves) begin
         span = span * TREE_FAN;
         lv   = lv + 1;
      end
      return lv;
   endfunction

endpackage

### rtl/core/ple_cell.sv
// one cell of the list chain: holds one element and its select leaf
module ple_cell #(
   parameter int WORD_BITS = ple_pkg::WORD_BITS_DEFAULT,
   parameter int IDX_BITS  = 8,
   parameter int INDEX     = 0
) (
   input  logic                  clock,
   input  ple_pkg::cell_ctl_type ctl,
   input  logic [IDX_BITS-1:0]   target,
   input  logic [WORD_BITS-1:0]  new_word,
   input  logic [WORD_BITS-1:0]  left_word,
   input  logic [WORD_BITS-1:0]  right_word,
   output logic [WORD_BITS-1:0]  word,
   output logic [WORD_BITS-1:0]  leaf
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic [WORD_BITS-1:0] leaf_ff;
   logic                 hit;
   logic                 above;

   assign hit   = (target == IDX_BITS'(INDEX));
   assign above = (IDX_BITS'(INDEX) > target);

   // next element: shift from a neighbor, take the new word or hold
   always_comb begin
      unique case (ctl.op)
         ple_pkg::CELL_INSERT: begin
            if (above) begin
               word_in = left_word;
            end else if (hit) begin
               word_in = new_word;
            end else begin
               word_in = word_ff;
            end
         end
         ple_pkg::CELL_DELETE: begin
            word_in = (above || hit) ? right_word : word_ff;
         end
         ple_pkg::CELL_WRITE: begin
            word_in = hit ? new_word : word_ff;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   // element and leaf update on each accepted item, leaf sees the old element
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         word_ff <= word_in;
         leaf_ff <= (ctl.fetch && hit) ? word_ff : '0;
      end
   end

   assign word = word_ff;
   assign leaf = leaf_ff;

endmodule

### rtl/core/ple_or_tree.sv
// registered or-reduction tree that picks the one selected leaf
module ple_or_tree #(
   parameter int WIDTH  = ple_pkg::WORD_BITS_DEFAULT,
   parameter int LEAVES = ple_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);

   localparam int FAN    = ple_pkg::TREE_FAN;
   localparam int LEVELS = ple_pkg::tree_levels(LEAVES);
   localparam int PAD    = FAN ** LEVELS;
   localparam int NODES  = PAD / FAN;

   logic [WIDTH-1:0] leaf_pad [PAD];
   logic [WIDTH-1:0] node_ff  [LEVELS][NODES];

   // pad the leaves out to a full tree
   always_comb begin
      for (int n = 0; n < PAD; n++) begin
         leaf_pad[n] = (n < LEAVES) ? leaf[n] : '0;
      end
   end

   // each level folds groups of sixteen from the level below
   always_ff @(posedge clock) begin
      for (int l = 0; l < LEVELS; l++) begin
         for (int j = 0; j < NODES; j++) begin
            logic [WIDTH-1:0] acc;
            acc = '0;
            for (int i = 0; i < FAN; i++) begin
               if (l == 0) begin
                  acc = acc | leaf_pad[j * FAN + i];
               end else if (j * FAN + i < NODES) begin
                  acc = acc | node_ff[(l > 0) ? l - 1 : 0][j * FAN + i];
               end
            end
            node_ff[l][j] <= acc;
         end
      end
   end

   assign root = node_ff[LEVELS-1][0];

endmodule

### rtl/core/positional_list_engine.sv
// top level of the positional list engine
// An ordered list of up to CAPACITY signed words held in a chain of cells, one
// element per cell, addressed by 1-based position. Insert, delete and write
// move or replace elements in the chain in the cycle the item is accepted.
// The element returned by read and delete goes through a registered select
// tree of fan-in sixteen with ceil(log16(CAPACITY)) levels, CAPACITY being
// 256 by default, and then into the result register. The result register
// frees the input side, so the next item is taken while a finished result
// still waits. Status is 0 for ok, 1 for a bad position and 2 for an insert
// into a full list; errors change nothing and return a zero value. No
// clearing pass follows reset.
`include "assert_macros.svh"

module positional_list_engine #(
   parameter int CAPACITY  = ple_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = ple_pkg::WORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_item
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int POS_W  = ple_pkg::POS_BITS;
   localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int LEVELS = ple_pkg::tree_levels(CAPACITY);
   localparam int RUN_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_PARK = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic [RUN_W-1:0]           run_ff, run_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [1:0]                 status_ff, status_in;
   logic [ple_pkg::LEN_BITS-1:0] length_ff;
   logic                       reads_ff;
   logic                       rsp_valid_ff;
   ple_pkg::rsp_type           rsp_ff;

   logic                       accept;
   logic                       ok;
   logic                       out_free;
   logic                       load_out;
   logic [CMP_W-1:0]           pos_ext;
   logic [CMP_W-1:0]           cnt_ext;
   logic [IDX_W-1:0]           target;
   logic [WORD_BITS-1:0]       new_word;
   logic [WORD_BITS-1:0]       root;
   ple_pkg::cell_ctl_type      cell_ctl;
   logic [WORD_BITS-1:0]       cell_word [CAPACITY];
   logic [WORD_BITS-1:0]       cell_leaf [CAPACITY];

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign pos_ext  = CMP_W'(req_item.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign target   = IDX_W'(32'(req_item.position) - 32'd1);
   assign new_word = WORD_BITS'(req_item.value_in);
   assign ok       = (status_in == ple_pkg::STATUS_OK);

   // position and capacity checks
   always_comb begin
      status_in = ple_pkg::STATUS_OK;
      unique case (req_item.cmd)
         ple_pkg::CMD_INSERT: begin
            if (req_item.position == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
               status_in = ple_pkg::STATUS_BADPOS;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               status_in = ple_pkg::STATUS_FULL;
            end
         end
         default: begin
            if (req_item.position == '0 || pos_ext > cnt_ext) begin
               status_in = ple_pkg::STATUS_BADPOS;
            end
         end
      endcase
   end

   // element count after the item
   always_comb begin
      count_in = count_ff;
      if (accept && ok && req_item.cmd == ple_pkg::CMD_INSERT) begin
         count_in = count_ff + CNT_W'(1);
      end else if (accept && ok && req_item.cmd == ple_pkg::CMD_DELETE) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // chain control
   always_comb begin
      cell_ctl.load  = accept;
      cell_ctl.fetch = ok && (req_item.cmd == ple_pkg::CMD_DELETE ||
                              req_item.cmd == ple_pkg::CMD_READ);
      cell_ctl.op    = ple_pkg::CELL_HOLD;
      if (ok) begin
         unique case (req_item.cmd)
            ple_pkg::CMD_INSERT: cell_ctl.op = ple_pkg::CELL_INSERT;
            ple_pkg::CMD_DELETE: cell_ctl.op = ple_pkg::CELL_DELETE;
            ple_pkg::CMD_WRITE:  cell_ctl.op = ple_pkg::CELL_WRITE;
            default:             cell_ctl.op = ple_pkg::CELL_HOLD;
         endcase
      end
   end

   // the chain of cells
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;
      if (k == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_left
         assign left_word = cell_word[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_right
         assign right_word = cell_word[k+1];
      end
      ple_cell #(
         .WORD_BITS (WORD_BITS),
         .IDX_BITS  (IDX_W),
         .INDEX     (k)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .target     (target),
         .new_word   (new_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[k]),
         .leaf       (cell_leaf[k])
      );
   end

   // select tree for the element read or deleted
   ple_or_tree #(
      .WIDTH  (WORD_BITS),
      .LEAVES (CAPACITY)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_leaf),
      .root  (root)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == ST_PARK) && out_free;

   // sequencer: wait out the tree, then hand the result to the output register
   always_comb begin
      state_in = state_ff;
      run_in   = run_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               run_in   = RUN_W'(LEVELS - 1);
            end
         end
         ST_RUN: begin
            if (run_ff == '0) begin
               state_in = ST_PARK;
            end else begin
               run_in = run_ff - RUN_W'(1);
            end
         end
         ST_PARK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         run_ff   <= run_in;
         count_ff <= count_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // per-item result fields and the output register
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         length_ff <= ple_pkg::LEN_BITS'(count_in);
         reads_ff  <= cell_ctl.fetch;
      end
      if (load_out) begin
         rsp_ff.status    <= status_ff;
         rsp_ff.value_out <= ple_pkg::VALUE_BITS'(signed'(root));
         rsp_ff.length    <= length_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY))
   `ASSERT_NEXT(a_insert_grows, clock, reset,
      accept && ok && req_item.cmd == ple_pkg::CMD_INSERT,
      count_ff == CNT_W'($past(count_ff) + CNT_W'(1)))
   `ASSERT_NEXT(a_error_keeps_count, clock, reset, accept && !ok, $stable(count_ff))
   `ASSERT_IMPLIES(a_quiet_tree, clock, reset, load_out && !reads_ff, root == '0)
   `ASSERT_IMPLIES(a_result_from_park, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_PARK)

endmodule
